### design/lcs_pkg.sv
// lcs_pkg: shared command codes, result width and chain link type for the lcs engine
// used by lcs_cell and lcs_length_engine; no dependencies
`default_nettype none

package lcs_pkg;

	// command codes carried on the command port
	localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
	localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
	localparam logic [1:0] CMD_COMPUTE       = 2'd2;

	// width of the reported length
	localparam int unsigned OUT_W   = 7;
	localparam int unsigned OUT_MAX = 127;

	// control that travels with each element of the second sequence
	typedef struct packed {
		logic valid;
		logic last;
	} lcs_link_t;

endpackage

`default_nettype wire

### design/lcs_ram.sv
// lcs_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module lcs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### design/lcs_cell.sv
// lcs_cell: one row of the lcs table; holds one element of the first sequence
// depends on lcs_pkg
`default_nettype none

module lcs_cell
	import lcs_pkg::*;
#(
	parameter int unsigned ELEM_W = 32,
	parameter int unsigned LEN_W  = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              clear,
	input  wire logic              we,
	input  wire logic [ELEM_W-1:0] wdata,
	input  wire logic              active,
	input  wire lcs_link_t         link_in,
	input  wire logic [ELEM_W-1:0] b_in,
	input  wire logic [LEN_W-1:0]  up_in,
	input  wire logic [LEN_W-1:0]  diag_in,
	output lcs_link_t              link_out,
	output logic      [ELEM_W-1:0] b_out,
	output logic      [LEN_W-1:0]  up_out,
	output logic      [LEN_W-1:0]  diag_out
);

	logic [ELEM_W-1:0] elem_q;
	logic [ELEM_W-1:0] b_q;
	logic [LEN_W-1:0]  c_q;
	logic [LEN_W-1:0]  diag_q;
	logic [LEN_W-1:0]  c_next;
	lcs_link_t         link_q;

	// rows past the loaded length just pass the row above down the chain
	always_comb begin
		if (!active) begin
			c_next = up_in;
		end else if (b_in == elem_q) begin
			c_next = diag_in + LEN_W'(1);
		end else if (up_in > c_q) begin
			c_next = up_in;
		end else begin
			c_next = c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q <= link_in;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			elem_q <= wdata;
		end
		if (clear) begin
			c_q <= '0;
		end else if (link_in.valid) begin
			c_q    <= c_next;
			diag_q <= c_q;
			b_q    <= b_in;
		end
	end

	assign link_out = link_q;
	assign b_out    = b_q;
	assign up_out   = c_q;
	assign diag_out = diag_q;

endmodule

`default_nettype wire

### design/lcs_length_engine.sv
// lcs_length_engine: longest common subsequence length over two loaded sequences
// depends on lcs_pkg, lcs_ram, lcs_cell
//
//   channel | signals                      | handshake
//   --------+------------------------------+-------------------------------------
//   in      | command, element             | item taken when start & !busy
//   out     | lcs_length, overflow         | done high one cycle, no back pressure
//
// appends are accepted back to back
// a compute item keeps busy high while the second sequence streams from the ram (feed)
// and then walks through the chain of MAX_LEN cells until its last element leaves (drain);
// with an empty second sequence it returns to idle straight from feed
// done pulses in the same cycle that busy falls
// arst_n clears the counts, the drop flag, the sequencer, the results and the chain valids
// the receiver cannot stall; done is not held, but lcs_length stays until the next result
`default_nettype none

module lcs_length_engine
	import lcs_pkg::*;
#(
	parameter int unsigned MAX_LEN    = 64,
	parameter int unsigned ELEM_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  command,
	input  wire logic [31:0] element,
	output logic             done,
	output logic [6:0]       lcs_length,
	output logic             overflow
);

	// stored element width: the element port carries at most 32 bits
	localparam int unsigned STORE_W = (ELEM_WIDTH < 32) ? ELEM_WIDTH : 32;
	// counts and table values run from 0 to MAX_LEN
	localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);
	localparam int unsigned AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int unsigned WIDE_W  = CNT_W + OUT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FEED,
		ST_DRAIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] first_count_q;
	logic [CNT_W-1:0] second_count_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic             dropped_q;
	logic             done_q;
	logic [6:0]       lcs_length_q;
	logic             overflow_q;
	logic             rd_valid_s1;
	logic             rd_last_s1;

	logic             accept;
	logic             first_full;
	logic             second_full;
	logic             append_first;
	logic             append_second;
	logic             start_compute;
	logic             rd_en;
	logic             rd_last;
	logic [CNT_W-1:0] second_last;
	logic [STORE_W-1:0] elem_in;
	logic [STORE_W-1:0] rd_data;
	logic [WIDE_W-1:0]  tail_wide;
	logic [6:0]         tail_sat;

	// chain taps: index 0 feeds the first cell, index MAX_LEN is the tail
	lcs_link_t          link [MAX_LEN+1];
	logic [STORE_W-1:0] b_tap [MAX_LEN+1];
	logic [CNT_W-1:0]   up_tap [MAX_LEN+1];
	logic [CNT_W-1:0]   diag_tap [MAX_LEN+1];

	// input side decode
	assign accept        = start && !busy;
	assign first_full    = (first_count_q == CNT_W'(MAX_LEN));
	assign second_full   = (second_count_q == CNT_W'(MAX_LEN));
	assign append_first  = accept && (command == CMD_APPEND_FIRST) && !first_full;
	assign append_second = accept && (command == CMD_APPEND_SECOND) && !second_full;
	assign start_compute = accept && (command == CMD_COMPUTE);
	assign elem_in       = element[STORE_W-1:0];

	// read side of the second sequence
	assign second_last = CNT_W'(second_count_q - CNT_W'(1));
	assign rd_en       = (state_q == ST_FEED) && (second_count_q != '0);
	assign rd_last     = (rd_cnt_q == second_last);

	// second sequence lives in a ram and streams into the chain
	lcs_ram #(
		.WIDTH (STORE_W),
		.DEPTH (MAX_LEN)
	) u_second_ram (
		.clk   (clk),
		.we    (append_second),
		.waddr (second_count_q[AW-1:0]),
		.wdata (elem_in),
		.re    (rd_en),
		.raddr (rd_cnt_q[AW-1:0]),
		.rdata (rd_data)
	);

	// chain head: row zero of the table is all zeros
	assign link[0].valid = rd_valid_s1;
	assign link[0].last  = rd_last_s1;
	assign b_tap[0]      = rd_data;
	assign up_tap[0]     = '0;
	assign diag_tap[0]   = '0;

	// one cell per element of the first sequence; cells past the count pass through
	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		lcs_cell #(
			.ELEM_W (STORE_W),
			.LEN_W  (CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clear    (start_compute),
			.we       (append_first && (first_count_q == CNT_W'(i))),
			.wdata    (elem_in),
			.active   (first_count_q > CNT_W'(i)),
			.link_in  (link[i]),
			.b_in     (b_tap[i]),
			.up_in    (up_tap[i]),
			.diag_in  (diag_tap[i]),
			.link_out (link[i+1]),
			.b_out    (b_tap[i+1]),
			.up_out   (up_tap[i+1]),
			.diag_out (diag_tap[i+1])
		);
	end

	// saturate the tail value into the 7-bit result
	assign tail_wide = WIDE_W'(up_tap[MAX_LEN]);
	assign tail_sat  = (tail_wide > WIDE_W'(OUT_MAX)) ? 7'(OUT_MAX) : tail_wide[6:0];

	// sequencer: counts, drop flag, read pointer and the result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			first_count_q  <= '0;
			second_count_q <= '0;
			rd_cnt_q       <= '0;
			dropped_q      <= 1'b0;
			done_q         <= 1'b0;
			lcs_length_q   <= '0;
			overflow_q     <= 1'b0;
			rd_valid_s1    <= 1'b0;
			rd_last_s1     <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			rd_valid_s1 <= rd_en;
			rd_last_s1  <= rd_en && rd_last;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (command)
							CMD_APPEND_FIRST: begin
								if (first_full) begin
									dropped_q <= 1'b1;
								end else begin
									first_count_q <= first_count_q + CNT_W'(1);
								end
							end
							CMD_APPEND_SECOND: begin
								if (second_full) begin
									dropped_q <= 1'b1;
								end else begin
									second_count_q <= second_count_q + CNT_W'(1);
								end
							end
							CMD_COMPUTE: begin
								overflow_q <= dropped_q;
								rd_cnt_q   <= '0;
								state_q    <= ST_FEED;
							end
							default: begin
								// unused command: no effect
							end
						endcase
					end
				end
				ST_FEED: begin
					if (second_count_q == '0) begin
						// empty second sequence: nothing to stream
						done_q         <= 1'b1;
						lcs_length_q   <= '0;
						first_count_q  <= '0;
						second_count_q <= '0;
						dropped_q      <= 1'b0;
						state_q        <= ST_IDLE;
					end else begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
						if (rd_last) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					// the tail shows the final row once the last element leaves the chain
					if (link[MAX_LEN].valid && link[MAX_LEN].last) begin
						done_q         <= 1'b1;
						lcs_length_q   <= tail_sat;
						first_count_q  <= '0;
						second_count_q <= '0;
						dropped_q      <= 1'b0;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign lcs_length = lcs_length_q;
	assign overflow   = overflow_q;

`ifndef ASSERT_OFF
	// every compute item ends with exactly one result as busy drops
	a_done_on_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

	// a result only follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a compute item");

	// nothing leaves the chain while the block is idle
	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		link[MAX_LEN].valid |-> busy)
		else $error("chain output outside a compute");

	// counts never pass the sequence depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(first_count_q <= CNT_W'(MAX_LEN)) && (second_count_q <= CNT_W'(MAX_LEN)))
		else $error("sequence count out of range");

	// the chain is only fed while streaming
	a_feed_state: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> $past(state_q == ST_FEED))
		else $error("chain fed outside the feed state");
`endif

endmodule

`default_nettype wire
